### sv/pts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic tick task scheduler
// command codes, status codes, queue job format and back-end states
// ---------------------------------------------------------------------------
package pts_pkg;

   // number of priority slots in the task table
   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [4:0] SLOTS_LIMIT = 5'(SLOTS);

   // command codes on the request channel
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CREATE = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUE      = 3'd1,
      ST_NONE     = 3'd2,
      ST_NOINIT   = 3'd3,
      ST_NULL     = 3'd4,
      ST_NOTFOUND = 3'd5
   } status_type;

   // work classes decided by the front end
   typedef enum logic [1:0] {
      OP_TICK,
      OP_CREATE,
      OP_DELETE,
      OP_REPLY
   } op_type;

   // one queued job
   typedef struct packed {
      op_type      op;
      logic [7:0]  handle;
      logic [3:0]  slot;
      logic [15:0] period;
      status_type  status;
   } job_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      job_type job;
   } qhead_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

### sv/pts_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_if: channel interfaces of the periodic tick task scheduler
// request channel and result channel, each with valid/ready handshake
// ---------------------------------------------------------------------------

// request channel: one command per transaction
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  task_handle;
   logic [3:0]  slot;
   logic [15:0] period;

   modport source (output valid, output command, output task_handle, output slot,
                   output period, input ready);
   modport sink (input valid, input command, input task_handle, input slot,
                 input period, output ready);
endinterface

// result channel: one result per transaction
interface pts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] run_handle;
   logic [3:0] run_slot;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output run_handle, output run_slot, output status,
                   output last, input ready);
   modport sink (input valid, input run_handle, input run_slot, input status,
                 input last, output ready);
endinterface
`default_nettype wire

### sv/pts_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_front: request decoder
// accepts commands and classifies them into queue jobs, settling every
// case that needs no table access into a queued job that carries only its reply
// ---------------------------------------------------------------------------
module pts_front (
   pts_req_if.sink           req_chan,
   input  logic              enabled,
   output logic              push_valid,
   output pts_pkg::job_type  push_job,
   input  logic              push_ready
);
   import pts_pkg::*;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;

   // classify the incoming transaction
   always_comb begin
      push_job.handle = req_chan.task_handle;
      push_job.slot   = req_chan.slot;
      push_job.period = req_chan.period;
      push_job.op     = OP_REPLY;
      push_job.status = ST_OK;
      case (req_chan.command)
         CMD_TICK: begin
            if (!enabled) begin
               push_job.status = ST_NOINIT;
            end else begin
               push_job.op = OP_TICK;
            end
         end
         CMD_CREATE: begin
            if (!enabled) begin
               push_job.status = ST_NOINIT;
            end else if (req_chan.task_handle == 8'd0) begin
               push_job.status = ST_NULL;
            end else if ({1'b0, req_chan.slot} >= SLOTS_LIMIT) begin
               push_job.status = ST_NOTFOUND;
            end else begin
               push_job.op = OP_CREATE;
            end
         end
         CMD_DELETE: begin
            if (req_chan.task_handle == 8'd0) begin
               push_job.status = ST_NULL;
            end else begin
               push_job.op = OP_DELETE;
            end
         end
         default: begin
            push_job.status = ST_OK;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/pts_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_queue: two-entry job queue
// decouples the request decoder from the table sequencer
// ---------------------------------------------------------------------------
module pts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pts_pkg::job_type    push_job,
   output logic                push_ready,
   output pts_pkg::qhead_type  head,
   input  logic                pop
);
   import pts_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.job   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### sv/pts_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pts_back: task table and sequencer
// holds the slot table, walks it one slot a cycle for tick and delete
// unless a due result waits, and drives the registered result channel
// ---------------------------------------------------------------------------
module pts_back (
   input  logic                clock,
   input  logic                reset,
   input  pts_pkg::qhead_type  head,
   output logic                pop,
   pts_rsp_if.source           rsp_chan
);
   import pts_pkg::*;

   // slot table
   logic [SLOTS-1:0] active_ff;
   logic [7:0]       handle_ff  [SLOTS];
   logic [15:0]      period_ff  [SLOTS];
   logic [15:0]      counter_ff [SLOTS];

   logic             tbl_we;
   logic [IDX_W-1:0] tbl_addr;
   logic             tbl_active_in;
   logic [7:0]       tbl_handle_in;
   logic [15:0]      tbl_period_in;
   logic [15:0]      tbl_counter_in;

   // sequencer state
   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   op_type           op_ff, op_in;
   logic [7:0]       key_ff, key_in;
   logic             found_ff, found_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_handle_ff, pend_handle_in;
   logic [3:0]       pend_slot_ff, pend_slot_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_handle_ff, out_handle_in;
   logic [3:0]       out_slot_ff, out_slot_in;
   status_type       out_status_ff, out_status_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             cur_active;
   logic [15:0]      cnt_inc;
   logic             cur_due;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.run_handle = out_handle_ff;
   assign rsp_chan.run_slot   = out_slot_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.last       = out_last_ff;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign cur_active = active_ff[idx_ff];
   assign cnt_inc    = counter_ff[idx_ff] + 16'd1;
   assign cur_due    = cur_active && (cnt_inc == period_ff[idx_ff]);

   // next state, table writes and result generation
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      pend_slot_in   = pend_slot_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_handle_in  = out_handle_ff;
      out_slot_in    = out_slot_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      pop            = 1'b0;
      tbl_we         = 1'b0;
      tbl_addr       = idx_ff;
      tbl_active_in  = 1'b0;
      tbl_handle_in  = 8'd0;
      tbl_period_in  = 16'd0;
      tbl_counter_in = 16'd0;

      case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               case (head.job.op)
                  OP_TICK, OP_DELETE: begin
                     pop           = 1'b1;
                     op_in         = head.job.op;
                     key_in        = head.job.handle;
                     idx_in        = '0;
                     found_in      = 1'b0;
                     pend_valid_in = 1'b0;
                     state_in      = BK_WALK;
                  end
                  OP_CREATE: begin
                     if (out_free) begin
                        pop            = 1'b1;
                        tbl_we         = 1'b1;
                        tbl_addr       = head.job.slot[IDX_W-1:0];
                        tbl_active_in  = 1'b1;
                        tbl_handle_in  = head.job.handle;
                        tbl_period_in  = head.job.period;
                        tbl_counter_in = 16'd0;
                        out_valid_in   = 1'b1;
                        out_handle_in  = 8'd0;
                        out_slot_in    = 4'd0;
                        out_status_in  = ST_OK;
                        out_last_in    = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        out_valid_in  = 1'b1;
                        out_handle_in = 8'd0;
                        out_slot_in   = 4'd0;
                        out_status_in = head.job.status;
                        out_last_in   = 1'b1;
                     end
                  end
               endcase
            end
         end

         BK_WALK: begin
            if (op_ff == OP_TICK) begin
               // hold a due slot while an earlier due result cannot leave
               if (!(cur_due && pend_valid_ff && !out_free)) begin
                  if (cur_active) begin
                     tbl_we         = 1'b1;
                     tbl_active_in  = 1'b1;
                     tbl_handle_in  = handle_ff[idx_ff];
                     tbl_period_in  = period_ff[idx_ff];
                     tbl_counter_in = cur_due ? 16'd0 : cnt_inc;
                  end
                  if (cur_due) begin
                     if (pend_valid_ff) begin
                        out_valid_in  = 1'b1;
                        out_handle_in = pend_handle_ff;
                        out_slot_in   = pend_slot_ff;
                        out_status_in = ST_DUE;
                        out_last_in   = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_handle_in = handle_ff[idx_ff];
                     pend_slot_in   = 4'(idx_ff);
                  end
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == IDX_W'(SLOTS - 1)) begin
                     state_in = BK_DONE;
                  end
               end
            end else begin
               // delete clears every active slot that carries the handle
               if (cur_active && (handle_ff[idx_ff] == key_ff)) begin
                  tbl_we   = 1'b1;
                  found_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_in = BK_DONE;
               end
            end
         end

         BK_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_last_in   = 1'b1;
               out_handle_in = 8'd0;
               out_slot_in   = 4'd0;
               if (op_ff == OP_TICK) begin
                  if (pend_valid_ff) begin
                     out_handle_in = pend_handle_ff;
                     out_slot_in   = pend_slot_ff;
                     out_status_in = ST_DUE;
                  end else begin
                     out_status_in = ST_NONE;
                  end
               end else begin
                  out_status_in = found_ff ? ST_OK : ST_NOTFOUND;
               end
               pend_valid_in = 1'b0;
               state_in      = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      found_ff       <= found_in;
      pend_handle_ff <= pend_handle_in;
      pend_slot_ff   <= pend_slot_in;
      out_handle_ff  <= out_handle_in;
      out_slot_ff    <= out_slot_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   // slot active bits
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (tbl_we) begin
         active_ff[tbl_addr] <= tbl_active_in;
      end
   end

   // slot contents, meaningful only while active
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         handle_ff[tbl_addr]  <= tbl_handle_in;
         period_ff[tbl_addr]  <= tbl_period_in;
         counter_ff[tbl_addr] <= tbl_counter_in;
      end
   end

endmodule
`default_nettype wire

### sv/periodic_tick_task_scheduler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_tick_task_scheduler: table of periodic tasks, one per priority slot
// create, delete and tick commands in; due tasks reported per tick
// ---------------------------------------------------------------------------
// A create or a reply-only command (not initialised, null handle, slot out
// of range, unknown command) gives its one result once it leaves the
// two-entry job queue. A tick or a delete walks the sixteen slots one per
// cycle in the sequencer up to its last result; a tick gives one
// transaction per due slot in ascending slot order, or one "no task due"
// transaction, with last set on the final one. The walk pauses at a due
// slot while an earlier due result waits for the result channel. The
// request side keeps accepting until the queue holds two jobs.
// ---------------------------------------------------------------------------
module periodic_tick_task_scheduler (
   input  logic      clock,
   input  logic      reset,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);
   import pts_pkg::*;

   logic      enabled_ff;
   logic      push_valid;
   job_type   push_job;
   logic      push_ready;
   qhead_type head;
   logic      pop;

   // enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_write_enable) begin
         enabled_ff <= csr_write_data;
      end
   end

   pts_front u_front (
      .req_chan   (req_chan),
      .enabled    (enabled_ff),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   pts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   pts_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
